>>> hw/rtl/rgbh_pkg.sv
package rgbh_pkg;

	localparam int PIX_BITS = 8;
	localparam int OP_BITS  = 2;
	localparam int OUT_BITS = 24;

	localparam logic [OUT_BITS-1:0] OUT_MAX   = '1;
	localparam logic [PIX_BITS-1:0] TOP_RESET = 8'd255;

	localparam logic [OP_BITS-1:0] OP_COUNT = 2'd0;
	localparam logic [OP_BITS-1:0] OP_READ  = 2'd1;
	localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE,
		ST_FETCH
	} state_t;

	typedef struct packed {
		logic capture;
		logic bump;
		logic load;
		logic sweep;
		logic sweep_start;
		logic peak_clr;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic clr_last;
	} status_t;

endpackage

>>> hw/rtl/rgbh_ram.sv
module rgbh_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/rgbh_ctrl.sv
module rgbh_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [rgbh_pkg::OP_BITS-1:0]  operation,
	input  rgbh_pkg::status_t             status,
	output logic                          in_stall,
	output rgbh_pkg::cmd_t                cmd
);

	rgbh_pkg::state_t state_q;
	rgbh_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rgbh_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rgbh_pkg::ST_CLEAR: begin
				if (status.clr_last) begin
					state_d = rgbh_pkg::ST_IDLE;
				end
			end
			rgbh_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (operation)
						rgbh_pkg::OP_COUNT: state_d = rgbh_pkg::ST_UPDATE;
						rgbh_pkg::OP_READ:  state_d = rgbh_pkg::ST_FETCH;
						rgbh_pkg::OP_CLEAR: state_d = rgbh_pkg::ST_CLEAR;
						default:            state_d = rgbh_pkg::ST_IDLE;
					endcase
				end
			end
			rgbh_pkg::ST_UPDATE: state_d = rgbh_pkg::ST_IDLE;
			rgbh_pkg::ST_FETCH: begin
				if (status.out_free) begin
					state_d = rgbh_pkg::ST_IDLE;
				end
			end
			default: state_d = rgbh_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			rgbh_pkg::ST_CLEAR: begin
				cmd.sweep = 1'b1;
			end
			rgbh_pkg::ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
				if (in_valid && operation == rgbh_pkg::OP_CLEAR) begin
					cmd.peak_clr    = 1'b1;
					cmd.sweep_start = 1'b1;
				end
			end
			rgbh_pkg::ST_UPDATE: begin
				cmd.bump = 1'b1;
			end
			rgbh_pkg::ST_FETCH: begin
				cmd.load = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> hw/rtl/rgbh_datapath.sv
module rgbh_datapath #(
	parameter int BIN_COUNT  = 256,
	parameter int COUNT_BITS = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rgbh_pkg::cmd_t                  cmd,
	output rgbh_pkg::status_t               status,
	input  logic                            cfg_wr,
	input  logic [rgbh_pkg::PIX_BITS-1:0]   cfg_data,
	input  logic [rgbh_pkg::OP_BITS-1:0]    operation,
	input  logic [rgbh_pkg::PIX_BITS-1:0]   pixel_red,
	input  logic [rgbh_pkg::PIX_BITS-1:0]   pixel_green,
	input  logic [rgbh_pkg::PIX_BITS-1:0]   pixel_blue,
	input  logic [rgbh_pkg::PIX_BITS-1:0]   bin_index,
	input  logic                            out_stall,
	output logic                            out_valid,
	output logic [rgbh_pkg::OUT_BITS-1:0]   red_count,
	output logic [rgbh_pkg::OUT_BITS-1:0]   green_count,
	output logic [rgbh_pkg::OUT_BITS-1:0]   blue_count,
	output logic [rgbh_pkg::OUT_BITS-1:0]   red_peak,
	output logic [rgbh_pkg::OUT_BITS-1:0]   green_peak,
	output logic [rgbh_pkg::OUT_BITS-1:0]   blue_peak
);

	localparam int IDX_W = $clog2(BIN_COUNT);
	localparam int CMP_W = IDX_W + rgbh_pkg::PIX_BITS;
	localparam int CW    = (COUNT_BITS > rgbh_pkg::OUT_BITS) ? COUNT_BITS : rgbh_pkg::OUT_BITS;
	localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(BIN_COUNT - 1);

	logic [rgbh_pkg::PIX_BITS-1:0] top_q;
	logic [IDX_W-1:0]              addr_r_q, addr_g_q, addr_b_q;
	logic                          in_range_q;
	logic [IDX_W-1:0]              clr_q;
	logic [COUNT_BITS-1:0]         peak_r_q, peak_g_q, peak_b_q;
	logic                          out_valid_q;
	logic [rgbh_pkg::OUT_BITS-1:0] cnt_r_q, cnt_g_q, cnt_b_q;
	logic [rgbh_pkg::OUT_BITS-1:0] pk_r_q, pk_g_q, pk_b_q;

	logic [IDX_W-1:0]      bin_r, bin_g, bin_b, rd_idx;
	logic [IDX_W-1:0]      raddr_r, raddr_g, raddr_b;
	logic [IDX_W-1:0]      waddr_r, waddr_g, waddr_b;
	logic [COUNT_BITS-1:0] rdata_r, rdata_g, rdata_b;
	logic [COUNT_BITS-1:0] inc_r, inc_g, inc_b;
	logic [COUNT_BITS-1:0] wdata_r, wdata_g, wdata_b;
	logic                  we;
	logic                  is_read;

	function automatic logic [IDX_W-1:0] bin_of(input logic [rgbh_pkg::PIX_BITS-1:0] comp,
		input logic [rgbh_pkg::PIX_BITS-1:0] top);
		logic [rgbh_pkg::PIX_BITS-1:0] b;
		logic [CMP_W-1:0]              bw;
		b  = (comp > top) ? top : comp;
		bw = CMP_W'(b);
		if (bw > CMP_W'(BIN_COUNT - 1)) begin
			bw = CMP_W'(BIN_COUNT - 1);
		end
		return IDX_W'(bw);
	endfunction

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (v == '1) ? v : v + COUNT_BITS'(1);
	endfunction

	function automatic logic [rgbh_pkg::OUT_BITS-1:0] report(input logic [COUNT_BITS-1:0] v);
		logic [CW-1:0] ext;
		ext = CW'(v);
		return (ext > CW'(rgbh_pkg::OUT_MAX)) ? rgbh_pkg::OUT_MAX : rgbh_pkg::OUT_BITS'(ext);
	endfunction

	assign bin_r   = bin_of(pixel_red, top_q);
	assign bin_g   = bin_of(pixel_green, top_q);
	assign bin_b   = bin_of(pixel_blue, top_q);
	assign rd_idx  = IDX_W'(bin_index);
	assign is_read = (operation == rgbh_pkg::OP_READ);
	assign raddr_r = is_read ? rd_idx : bin_r;
	assign raddr_g = is_read ? rd_idx : bin_g;
	assign raddr_b = is_read ? rd_idx : bin_b;

	assign inc_r = sat_inc(rdata_r);
	assign inc_g = sat_inc(rdata_g);
	assign inc_b = sat_inc(rdata_b);

	assign we      = cmd.bump | cmd.sweep;
	assign waddr_r = cmd.sweep ? clr_q : addr_r_q;
	assign waddr_g = cmd.sweep ? clr_q : addr_g_q;
	assign waddr_b = cmd.sweep ? clr_q : addr_b_q;
	assign wdata_r = cmd.sweep ? '0 : inc_r;
	assign wdata_g = cmd.sweep ? '0 : inc_g;
	assign wdata_b = cmd.sweep ? '0 : inc_b;

	rgbh_ram #(.WIDTH(COUNT_BITS), .DEPTH(BIN_COUNT)) u_ram_red (
		.clk(clk), .we(we), .waddr(waddr_r), .wdata(wdata_r),
		.re(cmd.capture), .raddr(raddr_r), .rdata(rdata_r)
	);

	rgbh_ram #(.WIDTH(COUNT_BITS), .DEPTH(BIN_COUNT)) u_ram_green (
		.clk(clk), .we(we), .waddr(waddr_g), .wdata(wdata_g),
		.re(cmd.capture), .raddr(raddr_g), .rdata(rdata_g)
	);

	rgbh_ram #(.WIDTH(COUNT_BITS), .DEPTH(BIN_COUNT)) u_ram_blue (
		.clk(clk), .we(we), .waddr(waddr_b), .wdata(wdata_b),
		.re(cmd.capture), .raddr(raddr_b), .rdata(rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= rgbh_pkg::TOP_RESET;
		end else if (cfg_wr) begin
			top_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_r_q   <= bin_r;
			addr_g_q   <= bin_g;
			addr_b_q   <= bin_b;
			in_range_q <= (CMP_W'(bin_index) < CMP_W'(BIN_COUNT));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.sweep_start) begin
			clr_q <= '0;
		end else if (cmd.sweep) begin
			clr_q <= (clr_q == LAST_BIN) ? '0 : clr_q + IDX_W'(1);
		end
	end

	assign status.clr_last = (clr_q == LAST_BIN);
	assign status.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_r_q <= '0;
			peak_g_q <= '0;
			peak_b_q <= '0;
		end else if (cmd.peak_clr) begin
			peak_r_q <= '0;
			peak_g_q <= '0;
			peak_b_q <= '0;
		end else if (cmd.bump) begin
			if (inc_r > peak_r_q) begin
				peak_r_q <= inc_r;
			end
			if (inc_g > peak_g_q) begin
				peak_g_q <= inc_g;
			end
			if (inc_b > peak_b_q) begin
				peak_b_q <= inc_b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cnt_r_q <= in_range_q ? report(rdata_r) : '0;
			cnt_g_q <= in_range_q ? report(rdata_g) : '0;
			cnt_b_q <= in_range_q ? report(rdata_b) : '0;
			pk_r_q  <= report(peak_r_q);
			pk_g_q  <= report(peak_g_q);
			pk_b_q  <= report(peak_b_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign red_count   = cnt_r_q;
	assign green_count = cnt_g_q;
	assign blue_count  = cnt_b_q;
	assign red_peak    = pk_r_q;
	assign green_peak  = pk_g_q;
	assign blue_peak   = pk_b_q;

endmodule

>>> hw/rtl/rgb_channel_histogram.sv
// A count beat reads its bin, then writes it back; a read beat is loaded into the output register
// in the cycle after it is accepted, later if a result is still held.
// Input is stalled while a count, read or clear beat is in progress, so no new beat is taken
// until the last one is done. All three bin memories share one sequencer; each has its own
// read-modify-write path. Reset: arst_n is asynchronous and active low; afterwards a clearing
// pass zeroes every bin while input beats are stalled. top_value resets to 255, peaks to zero.
module rgb_channel_histogram #(
	parameter int BIN_COUNT  = 256,
	parameter int COUNT_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rgbh_pkg::PIX_BITS-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rgbh_pkg::OP_BITS-1:0]  operation,
	input  logic [rgbh_pkg::PIX_BITS-1:0] pixel_red,
	input  logic [rgbh_pkg::PIX_BITS-1:0] pixel_green,
	input  logic [rgbh_pkg::PIX_BITS-1:0] pixel_blue,
	input  logic [rgbh_pkg::PIX_BITS-1:0] bin_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rgbh_pkg::OUT_BITS-1:0] red_count,
	output logic [rgbh_pkg::OUT_BITS-1:0] green_count,
	output logic [rgbh_pkg::OUT_BITS-1:0] blue_count,
	output logic [rgbh_pkg::OUT_BITS-1:0] red_peak,
	output logic [rgbh_pkg::OUT_BITS-1:0] green_peak,
	output logic [rgbh_pkg::OUT_BITS-1:0] blue_peak
);

	// The controller steps through idle, bin update, result fetch and the clearing sweep.
	// The datapath holds the three bin memories, the peak registers, the top_value
	// register and the output register. They talk only through the command and status
	// structs below.
	rgbh_pkg::cmd_t    cmd;
	rgbh_pkg::status_t status;
	logic              in_accept;

	// The register only matters between items, so the port can always take a beat.
	assign cfg_ready = 1'b1;
	assign in_accept = in_valid && !in_stall;

	rgbh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.operation(operation),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// A component above top_value lands in bin top_value, and a bin beyond the memory in
	// the last one. Counts and peaks saturate at their full width.
	rgbh_datapath #(
		.BIN_COUNT (BIN_COUNT),
		.COUNT_BITS(COUNT_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_wr     (cfg_valid),
		.cfg_data   (cfg_data),
		.operation  (operation),
		.pixel_red  (pixel_red),
		.pixel_green(pixel_green),
		.pixel_blue (pixel_blue),
		.bin_index  (bin_index),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.red_count  (red_count),
		.green_count(green_count),
		.blue_count (blue_count),
		.red_peak   (red_peak),
		.green_peak (green_peak),
		.blue_peak  (blue_peak)
	);

`ifndef SYNTHESIS
	// A count beat holds the input for exactly its write-back cycle.
	a_count_two_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && operation == rgbh_pkg::OP_COUNT |=> in_stall ##1 !in_stall)
		else $error("count beat did not take exactly two cycles");

	// A read beat keeps the sequencer busy until its result is loaded.
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && operation == rgbh_pkg::OP_READ |=> in_stall)
		else $error("input taken while a read was outstanding");

	// A result is only loaded from the fetch step, never straight from idle.
	a_result_from_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a fetch step");
`endif

endmodule
